// ----- rtl/ssfb_pkg.sv -----
// shared types, constants and lookup functions of the seven-segment frame builder
package ssfb_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned ValueW = 14;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BrightW = 4;
  localparam int unsigned StepW  = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned PlaceW = 2;

  localparam logic [ValueW-1:0]  ValueMax    = 14'd9999;
  localparam logic [StepW-1:0]   StepMax     = 4'd8;
  localparam logic [StepW-1:0]   FirstDigit  = 4'd2;
  localparam logic [BrightW-1:0] BrightReset = 4'hF;

  localparam logic [ByteW-1:0] CmdData = 8'h40;
  localparam logic [ByteW-1:0] CmdAddr = 8'hC0;
  localparam logic [ByteW-1:0] CmdCtrl = 8'h80;

  typedef enum logic [ModeW-1:0] {
    MODE_SHOW  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_CTRL  = 2'd2,
    MODE_INIT  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    SLOT_DATA_CMD = 3'd0,
    SLOT_ADDR_CMD = 3'd1,
    SLOT_CTRL_CMD = 3'd2,
    SLOT_DIGIT    = 3'd3,
    SLOT_BLANK    = 3'd4
  } slot_kind_e;

  typedef struct packed {
    slot_kind_e kind;
    logic       start;
    logic       stop;
    logic       last;
  } slot_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
    logic             frame_end;
    logic             last;
  } out_beat_t;

  function automatic slot_t mk_slot(slot_kind_e kind, logic start, logic stop, logic last);
    slot_t s;
    s.kind  = kind;
    s.start = start;
    s.stop  = stop;
    s.last  = last;
    return s;
  endfunction

  // byte schedule for each command
  function automatic slot_t slot_of(mode_e mode, logic [StepW-1:0] step);
    slot_t s;
    s = mk_slot(SLOT_BLANK, 1'b0, 1'b0, 1'b1);
    case (mode)
      MODE_SHOW: begin
        case (step)
          4'd0:    s = mk_slot(SLOT_DATA_CMD, 1'b1, 1'b1, 1'b0);
          4'd1:    s = mk_slot(SLOT_ADDR_CMD, 1'b1, 1'b0, 1'b0);
          4'd2:    s = mk_slot(SLOT_DIGIT,    1'b0, 1'b0, 1'b0);
          4'd3:    s = mk_slot(SLOT_DIGIT,    1'b0, 1'b0, 1'b0);
          4'd4:    s = mk_slot(SLOT_DIGIT,    1'b0, 1'b0, 1'b0);
          4'd5:    s = mk_slot(SLOT_DIGIT,    1'b0, 1'b1, 1'b0);
          default: s = mk_slot(SLOT_CTRL_CMD, 1'b1, 1'b1, 1'b1);
        endcase
      end
      MODE_CLEAR: begin
        case (step)
          4'd0:    s = mk_slot(SLOT_DATA_CMD, 1'b1, 1'b1, 1'b0);
          4'd1:    s = mk_slot(SLOT_ADDR_CMD, 1'b1, 1'b0, 1'b0);
          4'd2:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          4'd3:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          4'd4:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          default: s = mk_slot(SLOT_BLANK,    1'b0, 1'b1, 1'b1);
        endcase
      end
      MODE_CTRL: begin
        s = mk_slot(SLOT_CTRL_CMD, 1'b1, 1'b1, 1'b1);
      end
      default: begin
        case (step)
          4'd0:    s = mk_slot(SLOT_DATA_CMD, 1'b1, 1'b1, 1'b0);
          4'd1:    s = mk_slot(SLOT_ADDR_CMD, 1'b1, 1'b1, 1'b0);
          4'd2:    s = mk_slot(SLOT_CTRL_CMD, 1'b1, 1'b1, 1'b0);
          4'd3:    s = mk_slot(SLOT_DATA_CMD, 1'b1, 1'b1, 1'b0);
          4'd4:    s = mk_slot(SLOT_ADDR_CMD, 1'b1, 1'b0, 1'b0);
          4'd5:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          4'd6:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          4'd7:    s = mk_slot(SLOT_BLANK,    1'b0, 1'b0, 1'b0);
          default: s = mk_slot(SLOT_BLANK,    1'b0, 1'b1, 1'b1);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [ByteW-1:0] seg_code(logic [DigitW-1:0] d);
    logic [ByteW-1:0] c;
    case (d)
      4'd0:    c = 8'h3F;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5B;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h7D;
      4'd7:    c = 8'h07;
      4'd8:    c = 8'h7F;
      4'd9:    c = 8'h6F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // digit times decimal weight of the place, thousands first
  function automatic logic [ValueW-1:0] place_weight(logic [PlaceW-1:0] place,
                                                     logic [DigitW-1:0] d);
    logic [ValueW-1:0] w;
    case (place)
      2'd0:    w = ValueW'(d) * 14'd1000;
      2'd1:    w = ValueW'(d) * 14'd100;
      2'd2:    w = ValueW'(d) * 14'd10;
      default: w = ValueW'(d);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/ssfb_if.sv -----
// valid/ready channel interfaces for command input and byte output
interface ssfb_in_if;
  import ssfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ssfb_out_if;
  import ssfb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             frame_start;
  logic             frame_end;
  logic             last;

  modport source (output valid, output data_byte, output frame_start, output frame_end,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input frame_start, input frame_end,
                  input last, output ready);
endinterface

// ----- rtl/ssfb_digit.sv -----
// one decimal digit extraction step: digit of a place, its segment code and the remainder
module ssfb_digit (
  input  logic [ssfb_pkg::ValueW-1:0] rem_i,
  input  logic [ssfb_pkg::PlaceW-1:0] place_i,
  output logic [ssfb_pkg::ByteW-1:0]  seg_o,
  output logic [ssfb_pkg::ValueW-1:0] rem_next_o
);
  import ssfb_pkg::*;

  logic [DigitW-1:0] digit;

  // parallel threshold compares, highest passing multiple wins
  always_comb begin
    digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_i >= place_weight(place_i, DigitW'(k))) digit = DigitW'(k);
    end
  end

  assign rem_next_o = rem_i - place_weight(place_i, digit);
  assign seg_o      = seg_code(digit);

endmodule

// ----- rtl/ssfb_seq.sv -----
// command register and byte sequencer, one output byte per advance
module ssfb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  ssfb_pkg::mode_e              mode_i,
  input  logic [ssfb_pkg::ValueW-1:0]  value_i,
  input  logic                         advance_i,
  input  logic [ssfb_pkg::BrightW-1:0] brightness_i,
  output logic                         busy_o,
  output ssfb_pkg::out_beat_t          beat_o
);
  import ssfb_pkg::*;

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  mode_e             mode_q, mode_d;
  logic [ValueW-1:0] rem_q, rem_d;
  slot_t             slot;
  logic [ByteW-1:0]  seg;
  logic [ValueW-1:0] rem_next;
  logic [PlaceW-1:0] place;

  assign slot  = slot_of(mode_q, step_q);
  assign place = PlaceW'(step_q - FirstDigit);

  ssfb_digit u_digit (
    .rem_i      (rem_q),
    .place_i    (place),
    .seg_o      (seg),
    .rem_next_o (rem_next)
  );

  always_comb begin
    beat_o.frame_start = slot.start;
    beat_o.frame_end   = slot.stop;
    beat_o.last        = slot.last;
    case (slot.kind)
      SLOT_DATA_CMD: beat_o.data_byte = CmdData;
      SLOT_ADDR_CMD: beat_o.data_byte = CmdAddr;
      SLOT_CTRL_CMD: beat_o.data_byte = CmdCtrl | ByteW'(brightness_i);
      SLOT_DIGIT:    beat_o.data_byte = seg;
      default:       beat_o.data_byte = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    mode_d = mode_q;
    rem_d  = rem_q;
    if (load_i) begin
      busy_d = 1'b1;
      step_d = '0;
      mode_d = mode_i;
      rem_d  = (value_i > ValueMax) ? ValueMax : value_i;
    end else if (advance_i) begin
      if (slot.last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 4'd1;
      end
      if (slot.kind == SLOT_DIGIT) rem_d = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;

endmodule

// ----- rtl/seven_segment_frame_builder_unit.sv -----
// top level: command to byte-frame builder for a four-digit seven-segment driver
// a command is first captured in the sequencer registers; its first byte then moves into
// the output register once that register is empty or being drained
// one byte per cycle unless stalled; show is 7 bytes, clear 6, control 1, initialize 9
// the single output register sets the byte rate, one byte a cycle when empty or drained
// reset: asynchronous active low, clears busy, step and output valid, brightness to 15
module seven_segment_frame_builder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssfb_pkg::BrightW-1:0] cfg_wdata_i,
  ssfb_in_if.sink                      in_i,
  ssfb_out_if.source                   out_o
);
  import ssfb_pkg::*;

  logic [BrightW-1:0] brightness_q;
  logic               out_valid_q;
  out_beat_t          out_beat_q;
  out_beat_t          beat;
  logic               busy;
  logic               advance;
  logic               load;

  // brightness register; the user writes it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BrightReset;
    end else if (cfg_we_i) begin
      brightness_q <= cfg_wdata_i;
    end
  end

  // a byte moves into the output register when it is empty or being drained
  assign advance = busy && (!out_valid_q || out_o.ready);

  // a new command enters when the sequencer is idle or hands over its final byte
  assign in_i.ready = !busy || (advance && beat.last);
  assign load       = in_i.valid && in_i.ready;

  ssfb_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .mode_i       (mode_e'(in_i.mode)),
    .value_i      (in_i.value),
    .advance_i    (advance),
    .brightness_i (brightness_q),
    .busy_o       (busy),
    .beat_o       (beat)
  );

  // output register, holds a byte until its transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_beat_q <= beat;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_byte   = out_beat_q.data_byte;
  assign out_o.frame_start = out_beat_q.frame_start;
  assign out_o.frame_end   = out_beat_q.frame_end;
  assign out_o.last        = out_beat_q.last;

  // no new command while a stalled sequence still has bytes to go
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !advance) |-> !in_i.ready)
    else $error("command taken while sequence stalled");

  // the final byte of every command closes a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> out_o.frame_end)
    else $error("last byte does not close a frame");

  // a waiting byte stays valid until its transaction completes, checked while not busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !out_o.ready && out_o.valid) |=> out_o.valid)
    else $error("output byte dropped without transaction");

endmodule
